[rtl/vfcm_pkg.sv]
// Shared constants, types and the face shading table of the voxel mesher.
package vfcm_pkg;

  localparam int SIDE      = 16;
  localparam int CW        = $clog2(SIDE);
  localparam int COORD_W   = 7;
  localparam int TYPE_W    = 4;
  localparam int LEVEL_W   = 5;
  localparam int QUAD_W    = 4;
  localparam int FACE_W    = 3;
  localparam int CHAN_W    = 9;
  localparam int VC_W      = 17;
  localparam int VOX_AW    = 3 * CW;
  localparam int COL_AW    = 2 * CW;
  localparam int NUM_FACES = 6;
  localparam int SHADE_DEN = 1000;

  localparam logic [VC_W-1:0] VC_STEP = VC_W'(4);

  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NZ     = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PZ     = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NX     = 3'd4;
  localparam logic [FACE_W-1:0] FACE_PX     = 3'd5;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_QUAD = 1'b1;

  localparam logic [TYPE_W-1:0] TYPE_AIR = '0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_LEVEL = 2'd1,
    OP_READ  = 2'd2,
    OP_MESH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_READ_OUT,
    S_SCAN,
    S_SETTLE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              latch;
    logic              clr_step;
    logic              voxel_wr;
    logic              level_wr;
    logic              rd_cell;
    logic              rd_face;
    logic [FACE_W-1:0] face;
    logic              clear_vc;
    logic              emit_read;
    logic              emit_quad;
  } vfcm_cmd_t;

  typedef struct packed {
    op_t  op;
    logic start;
    logic in_xyz;
    logic in_xz;
    logic clr_last;
    logic out_free;
    logic mesh_ok;
    logic mask_last;
  } vfcm_sts_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [2:0]       rgb_t;
  typedef rgb_t [NUM_FACES-1:0] face_rgb_t;
  typedef face_rgb_t [(1 << TYPE_W)-1:0] shade_tab_t;

  // Base colors in hundredths, channel 0 is red.
  function automatic int base_color(int t, int ch);
    logic [23:0] rgb;
    case (t)
      1:       rgb = {8'd20, 8'd80, 8'd30};
      2:       rgb = {8'd60, 8'd40, 8'd20};
      3:       rgb = {8'd50, 8'd50, 8'd50};
      4:       rgb = {8'd20, 8'd40, 8'd80};
      5:       rgb = {8'd90, 8'd80, 8'd50};
      6:       rgb = {8'd95, 8'd95, 8'd95};
      7:       rgb = {8'd50, 8'd30, 8'd10};
      8:       rgb = {8'd30, 8'd70, 8'd30};
      default: rgb = {8'd100, 8'd100, 8'd100};
    endcase
    case (ch)
      0:       return int'(rgb[23:16]);
      1:       return int'(rgb[15:8]);
      default: return int'(rgb[7:0]);
    endcase
  endfunction

  // Face brightness in tenths.
  function automatic int face_factor(int f);
    case (f)
      0:       return 12;
      1:       return 8;
      2, 3:    return 10;
      default: return 9;
    endcase
  endfunction

  function automatic shade_tab_t build_shade_tab();
    shade_tab_t tab;
    int         prod;
    for (int t = 0; t < (1 << TYPE_W); t++) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        for (int ch = 0; ch < 3; ch++) begin
          prod = base_color(t, ch) * face_factor(f) * 256 + SHADE_DEN / 2;
          tab[t][f][ch] = CHAN_W'(prod / SHADE_DEN);
        end
      end
    end
    return tab;
  endfunction

  localparam shade_tab_t SHADE_TAB = build_shade_tab();

endpackage

[rtl/voxel_face_culling_mesher_core.sv]
// Write and level ops finish in the execute state; the read-out state loads a read result.
// Mesh: an execute state, 6 neighbor reads and a settle state on the single voxel RAM
// read port, then one quad per cycle while the output is taken.
// One item is in work at a time; the next is taken once the last result is registered.
// Reset (synchronous, rst high) starts a clearing pass over the 2^(3*log2(SIDE)) = 4096
// voxels, setting each to air and every column level to zero; no item is taken meanwhile.
module voxel_face_culling_mesher_core import vfcm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic signed [COORD_W-1:0] cell_x,
  input  logic signed [COORD_W-1:0] cell_y,
  input  logic signed [COORD_W-1:0] cell_z,
  input  logic [TYPE_W-1:0]         block_type,
  input  logic signed [LEVEL_W-1:0] column_height,
  input  logic                      start_mesh,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      result_kind,
  output logic [TYPE_W-1:0]         block_value,
  output logic [FACE_W-1:0]         face,
  output logic [QUAD_W-1:0]         quad_x,
  output logic [QUAD_W-1:0]         quad_y,
  output logic [QUAD_W-1:0]         quad_z,
  output logic [VC_W-1:0]           vertex_base,
  output logic [CHAN_W-1:0]         red,
  output logic [CHAN_W-1:0]         green,
  output logic [CHAN_W-1:0]         blue,
  output logic                      last
);

  vfcm_cmd_t cmd;
  vfcm_sts_t sts;

  vfcm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  vfcm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .block_type   (block_type),
    .column_height(column_height),
    .start_mesh   (start_mesh),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .block_value  (block_value),
    .face         (face),
    .quad_x       (quad_x),
    .quad_y       (quad_y),
    .quad_z       (quad_z),
    .vertex_base  (vertex_base),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last         (last)
  );

endmodule

[rtl/vfcm_ram.sv]
// Generic simple dual port RAM with registered read.
module vfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/vfcm_ctrl.sv]
// Controller state machine that sequences clearing, block access and meshing.
module vfcm_ctrl import vfcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  vfcm_sts_t sts,
  output vfcm_cmd_t cmd
);

  state_t            state;
  state_t            state_next;
  logic [FACE_W-1:0] face_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      face_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        face_cnt <= face_cnt + FACE_W'(1);
      end else begin
        face_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (sts.op)
          OP_READ: state_next = S_READ_OUT;
          OP_MESH: state_next = sts.in_xyz ? S_SCAN : S_IDLE;
          default: state_next = S_IDLE;
        endcase
      end
      S_READ_OUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (face_cnt == FACE_PX) state_next = S_SETTLE;
      end
      S_SETTLE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.mesh_ok) begin
          state_next = S_IDLE;
        end else if (sts.out_free && sts.mask_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.face = face_cnt;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        case (sts.op)
          OP_WRITE: cmd.voxel_wr = sts.in_xyz;
          OP_LEVEL: cmd.level_wr = sts.in_xz;
          OP_READ:  cmd.rd_cell  = 1'b1;
          OP_MESH: begin
            cmd.clear_vc = sts.start;
            cmd.rd_cell  = sts.in_xyz;
          end
          default: cmd.rd_cell = 1'b0;
        endcase
      end
      S_READ_OUT: cmd.emit_read = sts.out_free;
      S_SCAN:     cmd.rd_face   = 1'b1;
      S_EMIT:     cmd.emit_quad = sts.mesh_ok && sts.out_free;
      default:    cmd.latch     = 1'b0;
    endcase
  end

  // Reset always restarts the clearing pass.
  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("clearing pass did not start after reset");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("input ready outside the idle state");

  a_scan_face_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> face_cnt <= FACE_PX)
    else $error("face counter ran past the last face during the scan");

endmodule

[rtl/vfcm_datapath.sv]
// Datapath: voxel and column memories, neighbor scan, shading and result register.
module vfcm_datapath import vfcm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  vfcm_cmd_t                 cmd,
  output vfcm_sts_t                 sts,
  input  logic [1:0]                op,
  input  logic signed [COORD_W-1:0] cell_x,
  input  logic signed [COORD_W-1:0] cell_y,
  input  logic signed [COORD_W-1:0] cell_z,
  input  logic [TYPE_W-1:0]         block_type,
  input  logic signed [LEVEL_W-1:0] column_height,
  input  logic                      start_mesh,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      result_kind,
  output logic [TYPE_W-1:0]         block_value,
  output logic [FACE_W-1:0]         face,
  output logic [QUAD_W-1:0]         quad_x,
  output logic [QUAD_W-1:0]         quad_y,
  output logic [QUAD_W-1:0]         quad_z,
  output logic [VC_W-1:0]           vertex_base,
  output logic [CHAN_W-1:0]         red,
  output logic [CHAN_W-1:0]         green,
  output logic [CHAN_W-1:0]         blue,
  output logic                      last
);

  function automatic logic coord_inside(logic [COORD_W-1:0] v);
    return !v[COORD_W-1] && (v < COORD_W'(SIDE));
  endfunction

  op_t                 op_q;
  logic [COORD_W-1:0]  x_q;
  logic [COORD_W-1:0]  y_q;
  logic [COORD_W-1:0]  z_q;
  logic [TYPE_W-1:0]   type_q;
  logic [LEVEL_W-1:0]  lvl_q;
  logic                start_q;
  logic                in_xyz_q;
  logic                in_xz_q;
  logic [VOX_AW-1:0]   clr_addr;
  logic [VC_W-1:0]     vcount;

  logic                rd_vld;
  logic                rd_is_cell;
  logic [FACE_W-1:0]   rd_face_q;
  logic                rd_out_q;
  logic [TYPE_W-1:0]   cell_q;
  logic                cell_ok;
  logic [NUM_FACES-1:0] air_mask;

  logic [CW-1:0]       xc, yc, zc;
  logic [CW-1:0]       nx, ny, nz;
  logic                n_out;
  logic [FACE_W-1:0]   pick;
  logic                mask_last;
  logic                out_free;

  logic                vox_we;
  logic [VOX_AW-1:0]   vox_waddr;
  logic [TYPE_W-1:0]   vox_wdata;
  logic                vox_re;
  logic [VOX_AW-1:0]   vox_raddr;
  logic [TYPE_W-1:0]   vox_rdata;
  logic                col_we;
  logic [COL_AW-1:0]   col_waddr;
  logic [LEVEL_W-1:0]  col_wdata;
  logic [LEVEL_W-1:0]  col_rdata;
  logic [LEVEL_W-1:0]  lvl_sat;

  assign xc = x_q[CW-1:0];
  assign yc = y_q[CW-1:0];
  assign zc = z_q[CW-1:0];

  // Levels below the empty-column mark saturate to it.
  assign lvl_sat = (column_height < -LEVEL_W'(1)) ? '1 : column_height;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= op_t'(op);
      x_q      <= cell_x;
      y_q      <= cell_y;
      z_q      <= cell_z;
      type_q   <= block_type;
      lvl_q    <= lvl_sat;
      start_q  <= start_mesh;
      in_xyz_q <= coord_inside(cell_x) && coord_inside(cell_y) && coord_inside(cell_z);
      in_xz_q  <= coord_inside(cell_x) && coord_inside(cell_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + VOX_AW'(1);
    end
  end

  // Neighbor coordinates; a neighbor past the chunk edge counts as air.
  always_comb begin
    nx    = xc;
    ny    = yc;
    nz    = zc;
    n_out = 1'b0;
    case (cmd.face)
      FACE_TOP: begin
        ny    = yc + CW'(1);
        n_out = (yc == CW'(SIDE - 1));
      end
      FACE_BOTTOM: begin
        ny    = yc - CW'(1);
        n_out = (yc == '0);
      end
      FACE_NZ: begin
        nz    = zc - CW'(1);
        n_out = (zc == '0);
      end
      FACE_PZ: begin
        nz    = zc + CW'(1);
        n_out = (zc == CW'(SIDE - 1));
      end
      FACE_NX: begin
        nx    = xc - CW'(1);
        n_out = (xc == '0);
      end
      FACE_PX: begin
        nx    = xc + CW'(1);
        n_out = (xc == CW'(SIDE - 1));
      end
      default: n_out = 1'b1;
    endcase
  end

  assign vox_we    = cmd.clr_step || cmd.voxel_wr;
  assign vox_waddr = cmd.clr_step ? clr_addr : {zc, yc, xc};
  assign vox_wdata = cmd.clr_step ? TYPE_AIR : type_q;
  assign vox_re    = cmd.rd_cell || cmd.rd_face;
  assign vox_raddr = cmd.rd_face ? {nz, ny, nx} : {zc, yc, xc};

  assign col_we    = cmd.clr_step || cmd.level_wr;
  assign col_waddr = cmd.clr_step ? clr_addr[COL_AW-1:0] : {zc, xc};
  assign col_wdata = cmd.clr_step ? '0 : lvl_q;

  vfcm_ram #(
    .WIDTH(TYPE_W),
    .DEPTH(1 << VOX_AW)
  ) u_voxel_ram (
    .clk  (clk),
    .we   (vox_we),
    .waddr(vox_waddr),
    .wdata(vox_wdata),
    .re   (vox_re),
    .raddr(vox_raddr),
    .rdata(vox_rdata)
  );

  vfcm_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(1 << COL_AW)
  ) u_level_ram (
    .clk  (clk),
    .we   (col_we),
    .waddr(col_waddr),
    .wdata(col_wdata),
    .re   (cmd.rd_cell),
    .raddr({zc, xc}),
    .rdata(col_rdata)
  );

  // Read data arrives in the cycle after the address; a tag says what it belongs to.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vox_re;
    end
    rd_is_cell <= cmd.rd_cell;
    rd_face_q  <= cmd.face;
    rd_out_q   <= n_out;
  end

  always_comb begin
    pick = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (air_mask[i]) pick = FACE_W'(i);
    end
  end

  assign mask_last = (air_mask & (air_mask - NUM_FACES'(1))) == '0;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.rd_cell) begin
      air_mask <= '0;
    end else if (cmd.emit_quad) begin
      air_mask[pick] <= 1'b0;
    end else if (rd_vld && !rd_is_cell) begin
      air_mask[rd_face_q] <= rd_out_q || (vox_rdata == TYPE_AIR);
    end
    if (rd_vld && rd_is_cell) begin
      cell_q  <= vox_rdata;
      cell_ok <= (vox_rdata != TYPE_AIR) &&
                 !($signed(y_q) > $signed({{(COORD_W - LEVEL_W){col_rdata[LEVEL_W-1]}},
                                            col_rdata}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else if (cmd.clear_vc) begin
      vcount <= '0;
    end else if (cmd.emit_quad) begin
      vcount <= vcount + VC_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_read || cmd.emit_quad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_read) begin
      result_kind <= KIND_READ;
      block_value <= in_xyz_q ? vox_rdata : TYPE_AIR;
      face        <= '0;
      quad_x      <= '0;
      quad_y      <= '0;
      quad_z      <= '0;
      vertex_base <= '0;
      red         <= '0;
      green       <= '0;
      blue        <= '0;
      last        <= 1'b1;
    end else if (cmd.emit_quad) begin
      result_kind <= KIND_QUAD;
      block_value <= cell_q;
      face        <= pick;
      quad_x      <= x_q[QUAD_W-1:0];
      quad_y      <= y_q[QUAD_W-1:0];
      quad_z      <= z_q[QUAD_W-1:0];
      vertex_base <= vcount;
      red         <= SHADE_TAB[cell_q][pick][0];
      green       <= SHADE_TAB[cell_q][pick][1];
      blue        <= SHADE_TAB[cell_q][pick][2];
      last        <= mask_last;
    end
  end

  always_comb begin
    sts           = '0;
    sts.op        = op_q;
    sts.start     = start_q;
    sts.in_xyz    = in_xyz_q;
    sts.in_xz     = in_xz_q;
    sts.clr_last  = &clr_addr;
    sts.out_free  = out_free;
    sts.mesh_ok   = cell_ok && (air_mask != '0);
    sts.mask_last = mask_last;
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_read || cmd.emit_quad) |-> out_free)
    else $error("result loaded over an untaken result");

  a_vcount_step: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_quad |=> vcount == $past(vcount) + VC_STEP)
    else $error("vertex counter did not advance by one quad");

  a_read_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_READ) |-> last)
    else $error("read result without last flag");

endmodule

[tb/sv/tb.sv]
// Self-checking bench for the voxel face culling mesher core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vfcm_pkg::*;

  localparam int CYCLE_LIMIT    = 500_000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 110;
  localparam int FAST_ITEMS     = 12;
  localparam int SETTLE_CYCLES  = 30;

  typedef struct {
    op_t                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [TYPE_W-1:0]         btype;
    logic signed [LEVEL_W-1:0] height;
    logic                      start;
  } voxel_cmd_t;

  typedef struct {
    logic              kind;
    logic [TYPE_W-1:0] value;
    logic [FACE_W-1:0] face;
    logic [QUAD_W-1:0] qx;
    logic [QUAD_W-1:0] qy;
    logic [QUAD_W-1:0] qz;
    logic [VC_W-1:0]   vbase;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic              last;
  } mesh_result_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                op;
  logic signed [COORD_W-1:0] cell_x;
  logic signed [COORD_W-1:0] cell_y;
  logic signed [COORD_W-1:0] cell_z;
  logic [TYPE_W-1:0]         block_type;
  logic signed [LEVEL_W-1:0] column_height;
  logic                      start_mesh;
  logic                      out_valid;
  logic                      out_ready;
  logic                      result_kind;
  logic [TYPE_W-1:0]         block_value;
  logic [FACE_W-1:0]         face;
  logic [QUAD_W-1:0]         quad_x;
  logic [QUAD_W-1:0]         quad_y;
  logic [QUAD_W-1:0]         quad_z;
  logic [VC_W-1:0]           vertex_base;
  logic [CHAN_W-1:0]         red;
  logic [CHAN_W-1:0]         green;
  logic [CHAN_W-1:0]         blue;
  logic                      last;

  voxel_face_culling_mesher_core dut (.*);

  // Base colors in hundredths and face brightness in tenths.
  int base_rgb [16][3] = '{
    '{100, 100, 100}, '{20, 80, 30}, '{60, 40, 20}, '{50, 50, 50},
    '{20, 40, 80},    '{90, 80, 50}, '{95, 95, 95}, '{50, 30, 10},
    '{30, 70, 30},    '{100, 100, 100}, '{100, 100, 100}, '{100, 100, 100},
    '{100, 100, 100}, '{100, 100, 100}, '{100, 100, 100}, '{100, 100, 100}
  };
  int face_gain [NUM_FACES] = '{12, 8, 10, 10, 9, 9};
  int step_x [NUM_FACES] = '{0, 0, 0, 0, -1, 1};
  int step_y [NUM_FACES] = '{1, -1, 0, 0, 0, 0};
  int step_z [NUM_FACES] = '{0, 0, -1, 1, 0, 0};
  logic [FACE_W-1:0] face_code [NUM_FACES] =
    '{FACE_TOP, FACE_BOTTOM, FACE_NZ, FACE_PZ, FACE_NX, FACE_PX};

  // Mirror of the block's state.
  logic [TYPE_W-1:0] voxel_mirror [SIDE*SIDE*SIDE];
  int                column_mirror [SIDE*SIDE];
  logic [VC_W-1:0]   vertex_mirror;

  mesh_result_t results_due [$];

  int  mismatches  = 0;
  int  reads_seen  = 0;
  int  quads_seen  = 0;
  int  items_sent  = 0;
  int  burst_left  = 0;
  int  rx_hold_req = 0;
  bit  tx_fast     = 1'b0;
  bit  rx_fast     = 1'b0;
  int  cycles      = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit in_chunk(int x, int y, int z);
    return x >= 0 && x < SIDE && y >= 0 && y < SIDE && z >= 0 && z < SIDE;
  endfunction

  function automatic int vox_index(int x, int y, int z);
    return x + y * SIDE + z * SIDE * SIDE;
  endfunction

  function automatic logic [TYPE_W-1:0] block_at(int x, int y, int z);
    if (!in_chunk(x, y, z)) return TYPE_AIR;
    return voxel_mirror[vox_index(x, y, z)];
  endfunction

  function automatic logic [CHAN_W-1:0] shaded(int t, int f, int ch);
    return CHAN_W'((base_rgb[t][ch] * face_gain[f] * 256 + SHADE_DEN / 2) / SHADE_DEN);
  endfunction

  // Appends one result to the tail of the list of results still due.
  function automatic void queue_result(input mesh_result_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  function automatic voxel_cmd_t make_cmd(op_t o, int x, int y, int z, int t = 0,
                                          int h = 0, bit s = 1'b0);
    voxel_cmd_t c;
    c.op     = o;
    c.x      = COORD_W'(x);
    c.y      = COORD_W'(y);
    c.z      = COORD_W'(z);
    c.btype  = TYPE_W'(t);
    c.height = LEVEL_W'(h);
    c.start  = s;
    return c;
  endfunction

  function automatic voxel_cmd_t random_cmd();
    voxel_cmd_t c;
    c.op     = op_t'($urandom_range(0, 3));
    c.x      = COORD_W'($urandom);
    c.y      = COORD_W'($urandom);
    c.z      = COORD_W'($urandom);
    c.btype  = TYPE_W'($urandom);
    c.height = LEVEL_W'($urandom);
    c.start  = 1'($urandom);
    return c;
  endfunction

  // Updates the state mirror and queues the results that one command causes.
  task automatic apply_voxel_op(input voxel_cmd_t c);
    int                x, y, z, lv;
    logic [TYPE_W-1:0] cell_type;
    mesh_result_t      q;
    mesh_result_t      held;
    bit                have_held;
    x = c.x;
    y = c.y;
    z = c.z;
    lv = c.height;
    have_held = 1'b0;
    q = '{default: '0};
    held = q;
    case (c.op)
      OP_WRITE: begin
        if (in_chunk(x, y, z)) voxel_mirror[vox_index(x, y, z)] = c.btype;
      end
      OP_LEVEL: begin
        if (x >= 0 && x < SIDE && z >= 0 && z < SIDE)
          column_mirror[x + z * SIDE] = (lv < -1) ? -1 : ((lv > 15) ? 15 : lv);
      end
      OP_READ: begin
        q.kind  = KIND_READ;
        q.value = block_at(x, y, z);
        q.last  = 1'b1;
        queue_result(q);
      end
      default: begin
        if (c.start) vertex_mirror = '0;
        if (in_chunk(x, y, z)) begin
          cell_type = voxel_mirror[vox_index(x, y, z)];
          if (cell_type != TYPE_AIR && y <= column_mirror[x + z * SIDE]) begin
            for (int f = 0; f < NUM_FACES; f++) begin
              if (block_at(x + step_x[f], y + step_y[f], z + step_z[f]) == TYPE_AIR) begin
                if (have_held) queue_result(held);
                q.kind  = KIND_QUAD;
                q.value = cell_type;
                q.face  = face_code[f];
                q.qx    = QUAD_W'(x);
                q.qy    = QUAD_W'(y);
                q.qz    = QUAD_W'(z);
                q.vbase = vertex_mirror;
                q.r     = shaded(cell_type, f, 0);
                q.g     = shaded(cell_type, f, 1);
                q.b     = shaded(cell_type, f, 2);
                q.last  = 1'b0;
                held = q;
                have_held = 1'b1;
                vertex_mirror = vertex_mirror + VC_STEP;
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              queue_result(held);
            end
          end
        end
      end
    endcase
  endtask

  // Offers one command, waits for its transfer, then maybe drops valid for a gap.
  task automatic send_cmd(input voxel_cmd_t c);
    @(negedge clk);
    op            = c.op;
    cell_x        = c.x;
    cell_y        = c.y;
    cell_z        = c.z;
    block_type    = c.btype;
    column_height = c.height;
    start_mesh    = c.start;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_voxel_op(c);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !tx_fast) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic tx_pause();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    mesh_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result with nothing pending: kind %0d value %0d face %0d",
               result_kind, block_value, face);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (want.kind == KIND_READ) reads_seen++;
        else quads_seen++;
        compare_field("result_kind", want.kind, result_kind);
        compare_field("block_value", want.value, block_value);
        compare_field("face", want.face, face);
        compare_field("quad_x", want.qx, quad_x);
        compare_field("quad_y", want.qy, quad_y);
        compare_field("quad_z", want.qz, quad_z);
        compare_field("vertex_base", want.vbase, vertex_base);
        compare_field("red", want.r, red);
        compare_field("green", want.g, green);
        compare_field("blue", want.b, blue);
        compare_field("last", want.last, last);
      end
    end
  end

  // The receiver switches between stall patterns and serves long holds on request.
  initial begin : rx_pattern
    rx_mode_t mode;
    int       left, phase, hold, seen;
    out_ready = 1'b0;
    mode = RX_FREE;
    left = 0;
    phase = 0;
    hold = 0;
    seen = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != seen) begin
        seen = rx_hold_req;
        hold = RX_HOLD_CYCLES;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 80);
      end
      left--;
      phase++;
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (rx_fast) begin
        out_ready = 1'b1;
      end else begin
        case (mode)
          RX_FREE:   out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom);
          RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
          default:   out_ready = (phase % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_cmd(make_cmd(OP_READ, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 15, 15, 15));
    // An air cell emits nothing, but the start flag still clears the counter.
    send_cmd(make_cmd(OP_MESH, 5, 5, 5, 0, 0, 1'b1));
  endtask

  task automatic test_bounds();
    send_cmd(make_cmd(OP_WRITE, -1, 0, 0, 5));
    send_cmd(make_cmd(OP_WRITE, 16, 3, 3, 5));
    send_cmd(make_cmd(OP_WRITE, 0, -64, 0, 5));
    send_cmd(make_cmd(OP_WRITE, 63, 63, 63, 5));
    send_cmd(make_cmd(OP_READ, -64, -64, -64));
    send_cmd(make_cmd(OP_READ, 63, 0, 0));
    send_cmd(make_cmd(OP_LEVEL, -1, 0, 0, 0, -16));
    send_cmd(make_cmd(OP_LEVEL, 0, 0, 16, 0, 15));
  endtask

  task automatic test_faces();
    send_cmd(make_cmd(OP_WRITE, 7, 7, 7, 3));
    send_cmd(make_cmd(OP_LEVEL, 7, 0, 7, 0, 15));
    send_cmd(make_cmd(OP_MESH, 7, 7, 7, 0, 0, 1'b1));
    // A solid block above hides the top face.
    send_cmd(make_cmd(OP_WRITE, 7, 8, 7, 1));
    send_cmd(make_cmd(OP_MESH, 7, 7, 7));
    send_cmd(make_cmd(OP_MESH, 7, 8, 7));
    // The most negative level saturates to an empty column.
    send_cmd(make_cmd(OP_LEVEL, 7, 0, 7, 0, -16));
    send_cmd(make_cmd(OP_MESH, 7, 7, 7));
    send_cmd(make_cmd(OP_LEVEL, 7, 0, 7, 0, 15));
    send_cmd(make_cmd(OP_READ, 7, 8, 7, 0, 0, 1'b1));
    // A corner cell: neighbors outside the chunk count as air.
    send_cmd(make_cmd(OP_WRITE, 0, 0, 0, 15));
    send_cmd(make_cmd(OP_LEVEL, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_MESH, 0, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 0, 1, 0, 9));
    send_cmd(make_cmd(OP_MESH, 0, 1, 0));
  endtask

  task automatic test_output_hold();
    rx_hold_req++;
    repeat (5) send_cmd(make_cmd(OP_MESH, 7, 7, 7));
    send_cmd(make_cmd(OP_READ, 7, 7, 7));
  endtask

  // Meshes one fully exposed cell over and over with no gaps on either side.
  task automatic test_back_to_back();
    send_cmd(make_cmd(OP_WRITE, 12, 11, 10, 6));
    for (int f = 0; f < NUM_FACES; f++)
      send_cmd(make_cmd(OP_WRITE, 12 + step_x[f], 11 + step_y[f], 10 + step_z[f], 0));
    send_cmd(make_cmd(OP_LEVEL, 12, 0, 10, 0, 15));
    tx_fast = 1'b1;
    rx_fast = 1'b1;
    send_cmd(make_cmd(OP_MESH, 12, 11, 10, 0, 0, 1'b1));
    repeat (FAST_ITEMS - 1) send_cmd(make_cmd(OP_MESH, 12, 11, 10));
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  function automatic int pick_base();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return SIDE - 3;
      default: return $urandom_range(0, SIDE - 3);
    endcase
  endfunction

  // Rounds of building a small patch, setting its levels and meshing it, with noise.
  task automatic test_random_world();
    int target, bx, by, bz;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      bx = pick_base();
      by = pick_base();
      bz = pick_base();
      repeat (10)
        send_cmd(make_cmd(OP_WRITE, bx + $urandom_range(0, 2), by + $urandom_range(0, 2),
                          bz + $urandom_range(0, 2),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15)));
      repeat (4)
        send_cmd(make_cmd(OP_LEVEL, bx + $urandom_range(0, 2), 0, bz + $urandom_range(0, 2),
                          0, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                         : $urandom_range(by, 15)));
      for (int i = 0; i < 10; i++)
        send_cmd(make_cmd(OP_MESH, bx + $urandom_range(0, 2), by + $urandom_range(0, 2),
                          bz + $urandom_range(0, 2), $urandom_range(0, 15),
                          $urandom_range(0, 31), (i == 0) && ($urandom_range(0, 1) == 1)));
      repeat (2)
        send_cmd(make_cmd(OP_READ, bx + $urandom_range(0, 2), by + $urandom_range(0, 2),
                          bz + $urandom_range(0, 2), $urandom_range(0, 15), 0,
                          1'($urandom)));
      repeat (3) send_cmd(random_cmd());
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_WRITE;
    cell_x        = '0;
    cell_y        = '0;
    cell_z        = '0;
    block_type    = '0;
    column_height = '0;
    start_mesh    = 1'b0;
    vertex_mirror = '0;
    for (int i = 0; i < SIDE * SIDE * SIDE; i++) voxel_mirror[i] = TYPE_AIR;
    for (int i = 0; i < SIDE * SIDE; i++) column_mirror[i] = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_bounds();
    test_faces();
    test_output_hold();
    test_back_to_back();
    test_random_world();

    tx_pause();
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands; checked %0d block reads and %0d face quads.",
             items_sent, reads_seen, quads_seen);
    $display("Covered bounds, culling, level saturation, a gapless run, %0d long stall(s).",
             rx_hold_req);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
